// ===== design/mpi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpi_pkg
// Shared types, constants and the saturating adder of the Mandelbrot pixel
// iterator.
// ----------------------------------------------------------------------------
package mpi_pkg;

	localparam int WORD_W    = 64;
	localparam int STEP_W    = 62;
	localparam int COORD_W   = 9;
	localparam int COUNT_W   = 13;
	localparam int COLOUR_W  = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CHAN_W    = 8;

	localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_REAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_IMAG = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STEP  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT  = 2'd3;

	localparam logic [COUNT_W-1:0] LIMIT_RST = 13'd4096;
	localparam logic [CHAN_W-1:0]  ALPHA     = 8'hFF;
	localparam logic [CHAN_W-1:0]  BLUE_MUL  = 8'hF0;
	localparam logic [CHAN_W-1:0]  GREEN_DIV = 8'd240;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_col;
		logic [COORD_W-1:0] pixel_row;
	} pixel_in_t;

	typedef struct packed {
		logic [COORD_W-1:0]  out_col;
		logic [COORD_W-1:0]  out_row;
		logic [COUNT_W-1:0]  iteration_count;
		logic [COLOUR_W-1:0] colour_rgba;
	} pixel_out_t;

	function automatic logic signed [WORD_W-1:0] sat_add(
		input logic signed [WORD_W-1:0] a,
		input logic signed [WORD_W-1:0] b
	);
		logic signed [WORD_W:0] s;
		s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
		if (s[WORD_W] != s[WORD_W-1]) begin
			return s[WORD_W] ? WORD_MIN : WORD_MAX;
		end
		return s[WORD_W-1:0];
	endfunction

endpackage

// ===== design/mpi_serial_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpi_serial_mul
// Bit-serial signed fixed-point multiplier: one multiplier bit per cycle,
// magnitude truncated by the fraction bits, result saturated to the word.
// ----------------------------------------------------------------------------
module mpi_serial_mul
	import mpi_pkg::*;
#(
	parameter int FRACTION_BITS = 60
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [WORD_W-1:0] a,
	input  logic signed [WORD_W-1:0] b,
	output logic                     done,
	output logic signed [WORD_W-1:0] product
);

	localparam int CNT_W = $clog2(WORD_W);

	typedef enum logic [1:0] {MS_IDLE, MS_RUN, MS_FIN} mul_state_t;

	mul_state_t               state_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [WORD_W-1:0]        ua_q;
	logic [WORD_W-1:0]        ub_q;
	logic [WORD_W-1:0]        hi_q;
	logic [WORD_W-1:0]        lo_q;
	logic                     neg_q;
	logic                     done_q;
	logic signed [WORD_W-1:0] product_q;

	logic [WORD_W-1:0]   addend;
	logic [WORD_W:0]     sum;
	logic [2*WORD_W-1:0] full;
	logic [WORD_W-1:0]   rlo;
	logic                rhi_nz;
	logic signed [WORD_W-1:0] sat_val;

	assign addend = ub_q[0] ? ua_q : '0;
	assign sum    = {1'b0, hi_q} + {1'b0, addend};
	assign full   = {hi_q, lo_q};
	assign rlo    = WORD_W'(full >> FRACTION_BITS);
	assign rhi_nz = |(full >> (FRACTION_BITS + WORD_W));

	always_comb begin
		if (rhi_nz || rlo[WORD_W-1]) begin
			sat_val = neg_q ? WORD_MIN : WORD_MAX;
		end else begin
			sat_val = neg_q ? -$signed(rlo) : $signed(rlo);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MS_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				MS_IDLE: begin
					if (start) begin
						ua_q    <= a[WORD_W-1] ? WORD_W'(0) - a : a;
						ub_q    <= b[WORD_W-1] ? WORD_W'(0) - b : b;
						neg_q   <= a[WORD_W-1] ^ b[WORD_W-1];
						hi_q    <= '0;
						lo_q    <= '0;
						cnt_q   <= '0;
						state_q <= MS_RUN;
					end
				end
				MS_RUN: begin
					// add on the multiplier LSB, shift the product right
					hi_q  <= sum[WORD_W:1];
					lo_q  <= {sum[0], lo_q[WORD_W-1:1]};
					ub_q  <= ub_q >> 1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(WORD_W - 1)) begin
						state_q <= MS_FIN;
					end
				end
				MS_FIN: begin
					product_q <= sat_val;
					done_q    <= 1'b1;
					state_q   <= MS_IDLE;
				end
				default: begin
					state_q <= MS_IDLE;
				end
			endcase
		end
	end

	assign done    = done_q;
	assign product = product_q;

endmodule

// ===== design/mpi_point_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpi_point_map
// Maps one pixel coordinate to a point on an axis: origin plus step times
// coordinate, formed one coordinate bit per cycle, then saturated.
// ----------------------------------------------------------------------------
module mpi_point_map
	import mpi_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [WORD_W-1:0] origin,
	input  logic [STEP_W-1:0]        step,
	input  logic [COORD_W-1:0]       coord,
	output logic                     done,
	output logic signed [WORD_W-1:0] point
);

	localparam int ACC_W = STEP_W + COORD_W;
	localparam int CNT_W = $clog2(COORD_W);

	typedef enum logic [1:0] {PM_IDLE, PM_RUN, PM_FIN} map_state_t;

	map_state_t               state_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [COORD_W-1:0]       coord_q;
	logic [ACC_W-1:0]         acc_q;
	logic                     done_q;
	logic signed [WORD_W-1:0] point_q;

	logic [ACC_W-1:0]         acc_next;
	logic signed [WORD_W-1:0] offset;

	assign acc_next = (acc_q << 1) + (coord_q[COORD_W-1] ? ACC_W'(step) : '0);
	// hold the offset at the largest word when it does not fit
	assign offset   = (|acc_q[ACC_W-1:WORD_W-1]) ? WORD_MAX : $signed(acc_q[WORD_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PM_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				PM_IDLE: begin
					if (start) begin
						coord_q <= coord;
						acc_q   <= '0;
						cnt_q   <= '0;
						state_q <= PM_RUN;
					end
				end
				PM_RUN: begin
					acc_q   <= acc_next;
					coord_q <= coord_q << 1;
					cnt_q   <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(COORD_W - 1)) begin
						state_q <= PM_FIN;
					end
				end
				PM_FIN: begin
					point_q <= sat_add(origin, offset);
					done_q  <= 1'b1;
					state_q <= PM_IDLE;
				end
				default: begin
					state_q <= PM_IDLE;
				end
			endcase
		end
	end

	assign done  = done_q;
	assign point = point_q;

endmodule

// ===== design/mandelbrot_pixel_iterator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_pixel_iterator_core
// Escape-time Mandelbrot iterator for one pixel at a time: maps the pixel to
// c, runs z = z*z + c in signed fixed point and returns count and colour.
// ----------------------------------------------------------------------------
// From the start beat the core maps the pixel on both axes, then loops through
// test, update and multiply until escape or limit, then drives the result strobe.
// Each step waits on the three bit-serial 64-bit multipliers (one bit per cycle)
// that run side by side. One pixel is in flight; busy drops with the result strobe.
// Reset: asynchronous, active low; returns to idle and loads origin -2 - 2i,
// step 2^-7 and an iteration limit of 4096. The receiver cannot stall.
module mandelbrot_pixel_iterator_core
	import mpi_pkg::*;
#(
	parameter int IMAGE_SIZE    = 512,
	parameter int COUNT_BOUND   = 4096,
	parameter int FRACTION_BITS = 60
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// command channel
	input  logic                 start,
	output logic                 busy,
	input  pixel_in_t            pixel,
	// result channel
	output logic                 result_valid,
	output pixel_out_t           result,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	localparam logic signed [WORD_W-1:0] ORIGIN_RST = -(64'sd2 <<< FRACTION_BITS);
	localparam logic [STEP_W-1:0]        STEP_RST   = STEP_W'(64'd1 << (FRACTION_BITS - 7));
	localparam logic [WORD_W:0]          FOUR       = 65'd4 << FRACTION_BITS;

	typedef enum logic [2:0] {ST_IDLE, ST_MAP, ST_TEST, ST_UPD, ST_MUL} iter_state_t;

	// configuration registers
	logic signed [WORD_W-1:0] origin_real_q;
	logic signed [WORD_W-1:0] origin_imag_q;
	logic [STEP_W-1:0]        pixel_step_q;
	logic [COUNT_W-1:0]       iteration_limit_q;

	// iteration state
	iter_state_t              state_q;
	pixel_in_t                pixel_q;
	logic signed [WORD_W-1:0] cr_q;
	logic signed [WORD_W-1:0] ci_q;
	logic signed [WORD_W-1:0] x_q;
	logic signed [WORD_W-1:0] y_q;
	logic signed [WORD_W-1:0] x2_q;
	logic signed [WORD_W-1:0] y2_q;
	logic signed [WORD_W-1:0] p_q;
	logic signed [WORD_W-1:0] pp_q;
	logic signed [WORD_W-1:0] dxy_q;
	logic [COUNT_W-1:0]       count_q;
	logic [COUNT_W-1:0]       limit_q;
	logic [CHAN_W-1:0]        rem_q;
	logic [CHAN_W-1:0]        green_q;
	logic                     mul_start_q;
	logic                     result_valid_q;
	pixel_out_t               result_q;

	logic                     accept;
	logic [COORD_W-1:0]       col_clamped;
	logic [COORD_W-1:0]       row_clamped;
	logic [COUNT_W-1:0]       limit_eff;
	logic [WORD_W:0]          mag_sum;
	logic                     keep_going;
	logic                     map_done_re;
	logic                     map_done_im;
	logic signed [WORD_W-1:0] map_re;
	logic signed [WORD_W-1:0] map_im;
	logic                     done_xy;
	logic                     done_xx;
	logic                     done_yy;
	logic signed [WORD_W-1:0] prod_xy;
	logic signed [WORD_W-1:0] prod_xx;
	logic signed [WORD_W-1:0] prod_yy;

	function automatic logic signed [WORD_W-1:0] sat_sub(
		input logic signed [WORD_W-1:0] a,
		input logic signed [WORD_W-1:0] b
	);
		logic signed [WORD_W:0] s;
		s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
		if (s[WORD_W] != s[WORD_W-1]) begin
			return s[WORD_W] ? WORD_MIN : WORD_MAX;
		end
		return s[WORD_W-1:0];
	endfunction

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// hold coordinates beyond the image at its last pixel
	assign col_clamped = (32'(pixel.pixel_col) > (IMAGE_SIZE - 1)) ?
		COORD_W'(IMAGE_SIZE - 1) : pixel.pixel_col;
	assign row_clamped = (32'(pixel.pixel_row) > (IMAGE_SIZE - 1)) ?
		COORD_W'(IMAGE_SIZE - 1) : pixel.pixel_row;

	// hold the limit at the count bound
	assign limit_eff = (32'(iteration_limit_q) > COUNT_BOUND) ?
		COUNT_W'(COUNT_BOUND) : iteration_limit_q;

	// both squares are never negative, so the plain sum cannot wrap
	assign mag_sum    = {1'b0, x2_q} + {1'b0, y2_q};
	assign keep_going = (count_q < limit_q) && (mag_sum <= FOUR);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_real_q     <= ORIGIN_RST;
			origin_imag_q     <= ORIGIN_RST;
			pixel_step_q      <= STEP_RST;
			iteration_limit_q <= LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ORIGIN_REAL: origin_real_q     <= $signed(cfg_data);
				CFG_ORIGIN_IMAG: origin_imag_q     <= $signed(cfg_data);
				CFG_PIXEL_STEP:  pixel_step_q      <= cfg_data[STEP_W-1:0];
				CFG_ITER_LIMIT:  iteration_limit_q <= cfg_data[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// point mapping on both axes, started by the command beat
	mpi_point_map u_map_re (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.origin (origin_real_q),
		.step   (pixel_step_q),
		.coord  (col_clamped),
		.done   (map_done_re),
		.point  (map_re)
	);

	mpi_point_map u_map_im (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.origin (origin_imag_q),
		.step   (pixel_step_q),
		.coord  (row_clamped),
		.done   (map_done_im),
		.point  (map_im)
	);

	// three products of the new z, formed side by side
	mpi_serial_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul_xy (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start_q),
		.a       (x_q),
		.b       (y_q),
		.done    (done_xy),
		.product (prod_xy)
	);

	mpi_serial_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul_xx (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start_q),
		.a       (x_q),
		.b       (x_q),
		.done    (done_xx),
		.product (prod_xx)
	);

	mpi_serial_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul_yy (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start_q),
		.a       (y_q),
		.b       (y_q),
		.done    (done_yy),
		.product (prod_yy)
	);

	// sequencer: map, then test / update / multiply until escape or limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			mul_start_q    <= 1'b0;
			result_valid_q <= 1'b0;
			count_q        <= '0;
			limit_q        <= '0;
			rem_q          <= '0;
			green_q        <= '0;
		end else begin
			mul_start_q    <= 1'b0;
			result_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						pixel_q <= pixel;
						limit_q <= limit_eff;
						x_q     <= '0;
						y_q     <= '0;
						x2_q    <= '0;
						y2_q    <= '0;
						p_q     <= '0;
						count_q <= '0;
						rem_q   <= '0;
						green_q <= '0;
						state_q <= ST_MAP;
					end
				end
				ST_MAP: begin
					if (map_done_re && map_done_im) begin
						cr_q    <= map_re;
						ci_q    <= map_im;
						state_q <= ST_TEST;
					end
				end
				ST_TEST: begin
					if (keep_going) begin
						pp_q    <= sat_add(p_q, p_q);
						dxy_q   <= sat_sub(x2_q, y2_q);
						state_q <= ST_UPD;
					end else begin
						// drive the result beat for exactly one cycle
						result_q.out_col         <= pixel_q.pixel_col;
						result_q.out_row         <= pixel_q.pixel_row;
						result_q.iteration_count <= count_q;
						result_q.colour_rgba     <= {count_q[CHAN_W-1:0], green_q,
							CHAN_W'(count_q * BLUE_MUL), ALPHA};
						result_valid_q           <= 1'b1;
						state_q                  <= ST_IDLE;
					end
				end
				ST_UPD: begin
					y_q         <= sat_add(pp_q, ci_q);
					x_q         <= sat_add(dxy_q, cr_q);
					count_q     <= count_q + 1'b1;
					// advance count / 240 alongside the count
					if (rem_q == GREEN_DIV - 1'b1) begin
						rem_q   <= '0;
						green_q <= green_q + 1'b1;
					end else begin
						rem_q   <= rem_q + 1'b1;
					end
					mul_start_q <= 1'b1;
					state_q     <= ST_MUL;
				end
				ST_MUL: begin
					if (done_xy && done_xx && done_yy) begin
						p_q     <= prod_xy;
						x2_q    <= prod_xx;
						y2_q    <= prod_yy;
						state_q <= ST_TEST;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== tb/mandelbrot_pixel_scoreboard.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_pixel_scoreboard
// Watches the command, result and configuration channels of the pixel
// iterator, predicts count and colour of every accepted pixel and compares.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_scoreboard
	import mpi_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  pixel_in_t            pixel,
	input  logic                 result_valid,
	input  pixel_out_t           result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	output int                   in_flight,
	output int                   errors
);

	localparam int IMG_LAST  = 511;
	localparam int COUNT_CAP = 4096;
	localparam int FRAC      = 60;

	typedef logic signed [WORD_W-1:0] fixed_t;

	localparam fixed_t FIX_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam fixed_t FIX_MIN  = 64'sh8000_0000_0000_0000;
	localparam fixed_t FIX_FOUR = 64'sh4000_0000_0000_0000;
	localparam fixed_t FIX_NEG2 = 64'shE000_0000_0000_0000;

	// shadow of the view registers
	fixed_t              view_re;
	fixed_t              view_im;
	logic [STEP_W-1:0]   view_step;
	logic [COUNT_W-1:0]  view_limit;

	pixel_out_t awaited_px[$];
	pixel_out_t want;

	initial errors = 0;

	task automatic report(input string msg);
		$display("MISMATCH @%0t ns: %s", $time, msg);
		errors = errors + 1;
	endtask

	function automatic fixed_t fixed_add(input fixed_t a, input fixed_t b);
		fixed_t s;
		s = a + b;
		if (a[WORD_W-1] == b[WORD_W-1] && s[WORD_W-1] != a[WORD_W-1]) begin
			return a[WORD_W-1] ? FIX_MIN : FIX_MAX;
		end
		return s;
	endfunction

	function automatic fixed_t fixed_sub(input fixed_t a, input fixed_t b);
		fixed_t s;
		s = a - b;
		if (a[WORD_W-1] != b[WORD_W-1] && s[WORD_W-1] != a[WORD_W-1]) begin
			return a[WORD_W-1] ? FIX_MIN : FIX_MAX;
		end
		return s;
	endfunction

	// exact product, magnitude truncated toward zero, then saturated
	function automatic fixed_t fixed_mul(input fixed_t a, input fixed_t b);
		logic         neg;
		logic [63:0]  ma;
		logic [63:0]  mb;
		logic [127:0] prod;
		logic [127:0] mag;
		neg  = a[WORD_W-1] ^ b[WORD_W-1];
		ma   = a[WORD_W-1] ? (~a + 64'd1) : a;
		mb   = b[WORD_W-1] ? (~b + 64'd1) : b;
		prod = {64'd0, ma} * {64'd0, mb};
		mag  = prod >> FRAC;
		if (mag[127:63] != '0) begin
			return neg ? FIX_MIN : FIX_MAX;
		end
		return neg ? -$signed(mag[63:0]) : $signed(mag[63:0]);
	endfunction

	function automatic fixed_t pixel_point(input fixed_t origin, input logic [COORD_W-1:0] coord);
		int unsigned  c;
		logic [127:0] off_w;
		fixed_t       off;
		c = 32'(coord);
		if (c > IMG_LAST) begin
			c = IMG_LAST;
		end
		off_w = {66'd0, view_step} * c;
		off   = (off_w > 128'h7FFF_FFFF_FFFF_FFFF) ? FIX_MAX : $signed(off_w[63:0]);
		return fixed_add(origin, off);
	endfunction

	function automatic pixel_out_t escape_pixel(input pixel_in_t px);
		fixed_t     cr;
		fixed_t     ci;
		fixed_t     x;
		fixed_t     y;
		fixed_t     x2;
		fixed_t     y2;
		fixed_t     p;
		int         count;
		int         cap;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		pixel_out_t r;
		cr    = pixel_point(view_re, px.pixel_col);
		ci    = pixel_point(view_im, px.pixel_row);
		x     = '0;
		y     = '0;
		x2    = '0;
		y2    = '0;
		count = 0;
		cap   = (int'(view_limit) > COUNT_CAP) ? COUNT_CAP : int'(view_limit);
		while (count < cap && x2 <= FIX_FOUR && y2 <= FIX_FOUR - x2) begin
			p     = fixed_mul(x, y);
			y     = fixed_add(fixed_add(p, p), ci);
			x     = fixed_add(fixed_sub(x2, y2), cr);
			x2    = fixed_mul(x, x);
			y2    = fixed_mul(y, y);
			count = count + 1;
		end
		red               = 8'(count);
		green             = 8'(count / 240);
		blue              = 8'(count * 240);
		r.out_col         = px.pixel_col;
		r.out_row         = px.pixel_row;
		r.iteration_count = COUNT_W'(count);
		r.colour_rgba     = {red, green, blue, 8'hFF};
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_re    <= FIX_NEG2;
			view_im    <= FIX_NEG2;
			view_step  <= 62'h0020_0000_0000_0000;
			view_limit <= 13'd4096;
			in_flight  <= 0;
		end else begin
			// retire the result first: a new pixel may be accepted on its strobe
			if (result_valid) begin
				if (awaited_px.size() == 0) begin
					report($sformatf("result for (%0d,%0d) with no pixel outstanding",
						result.out_col, result.out_row));
				end else begin
					want = awaited_px.pop_front();
					if (result.out_col !== want.out_col)
						report($sformatf("out_col %0d, want %0d", result.out_col, want.out_col));
					if (result.out_row !== want.out_row)
						report($sformatf("out_row %0d, want %0d", result.out_row, want.out_row));
					if (result.iteration_count !== want.iteration_count)
						report($sformatf("pixel (%0d,%0d) count %0d, want %0d", want.out_col,
							want.out_row, result.iteration_count, want.iteration_count));
					if (result.colour_rgba !== want.colour_rgba)
						report($sformatf("pixel (%0d,%0d) colour %h, want %h", want.out_col,
							want.out_row, result.colour_rgba, want.colour_rgba));
				end
			end
			if (start && !busy) begin
				awaited_px.push_back(escape_pixel(pixel));
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_ORIGIN_REAL: view_re    <= cfg_data;
					CFG_ORIGIN_IMAG: view_im    <= cfg_data;
					CFG_PIXEL_STEP:  view_step  <= cfg_data[STEP_W-1:0];
					CFG_ITER_LIMIT:  view_limit <= cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			in_flight <= awaited_px.size();
		end
	end

endmodule

// ===== tb/mandelbrot_pixel_iterator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_pixel_iterator_core_tb
// Drives pixels and view settings into the escape-time iterator: a directed
// pass over reset values, saturating origins and steps, zero and clamped
// limits and points inside the set, then random views and pixels under
// varying start gaps. A scoreboard beside the core checks every result.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_iterator_core_tb;
	import mpi_pkg::*;

	// fixed point values, Q3.60
	localparam logic [WORD_W-1:0] FIX_ZERO   = 64'h0000_0000_0000_0000;
	localparam logic [WORD_W-1:0] FIX_NEG2   = 64'hE000_0000_0000_0000;
	localparam logic [WORD_W-1:0] FIX_NEG2P5 = 64'hD800_0000_0000_0000;
	localparam logic [WORD_W-1:0] FIX_NEGHALF = 64'hF800_0000_0000_0000;
	localparam logic [WORD_W-1:0] STEP_FINE  = 64'h0020_0000_0000_0000;
	localparam logic [WORD_W-1:0] STEP_TOP   = 64'h3FFF_FFFF_FFFF_FFFF;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	pixel_in_t            pixel;
	logic                 result_valid;
	pixel_out_t           result;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_data;
	int                   in_flight;
	int                   errors;
	int                   idle_pct;

	mandelbrot_pixel_iterator_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	mandelbrot_pixel_scoreboard scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_flight    (in_flight),
		.errors       (errors)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [WORD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// Offer one pixel. Idle first with the phase's odds, then hold start until
	// the beat lands on an edge where busy was low. Start stays high on return
	// so that back-to-back pixels never drop it within one step.
	task automatic issue_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		pixel <= {col, row};
		do @(posedge clk); while (busy);
	endtask

	// Drop start and wait until the core is idle and no result is owed.
	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (in_flight != 0 || busy);
	endtask

	task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	// Load a whole view: one write beat per register, back to back.
	task automatic set_view(input logic [WORD_W-1:0] re, input logic [WORD_W-1:0] im,
			input logic [WORD_W-1:0] step, input logic [WORD_W-1:0] limit);
		cfg_beat(CFG_ORIGIN_REAL, re);
		cfg_beat(CFG_ORIGIN_IMAG, im);
		cfg_beat(CFG_PIXEL_STEP, step);
		cfg_beat(CFG_ITER_LIMIT, limit);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int phase;
		int n;
		logic [WORD_W-1:0] lim;

		arst_n    <= 1'b0;
		start     <= 1'b0;
		pixel     <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_ORIGIN_REAL;
		cfg_data  <= '0;
		idle_pct  = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset view (-2-2i, step 1/128, limit 4096): pick pixels that escape
		// within two steps so the full limit never runs here.
		issue_pixel(9'd0, 9'd0);
		issue_pixel(9'd511, 9'd511);
		issue_pixel(9'd511, 9'd0);
		issue_pixel(9'd256, 9'd0);

		// Zero limit: no step at all, even on a point inside the set.
		wait_idle();
		set_view(FIX_NEG2, FIX_NEG2, STEP_FINE, 64'd0);
		issue_pixel(9'd256, 9'd256);
		issue_pixel(9'd100, 9'd300);

		// Origins at the word extremes, widest step, limit of one.
		wait_idle();
		set_view(WORD_MAX, WORD_MIN, STEP_TOP, 64'd1);
		issue_pixel(9'd0, 9'd0);
		issue_pixel(9'd511, 9'd511);
		issue_pixel(9'd1, 9'd0);

		// Swapped extremes; offsets saturate and the limit above the bound clamps.
		wait_idle();
		set_view(WORD_MIN, WORD_MAX, STEP_TOP, 64'd8191);
		issue_pixel(9'd0, 9'd0);
		issue_pixel(9'd511, 9'd511);
		issue_pixel(9'd0, 9'd511);

		// Zero step puts every pixel at c = 0: runs the clamped limit of 4096.
		wait_idle();
		set_view(FIX_ZERO, FIX_ZERO, 64'd0, 64'd8191);
		issue_pixel(9'd511, 9'd511);

		// Points inside reach the limit; the outer ones escape early.
		wait_idle();
		set_view(FIX_NEGHALF, FIX_ZERO, STEP_FINE, 64'd37);
		issue_pixel(9'd0, 9'd0);
		issue_pixel(9'd64, 9'd0);
		issue_pixel(9'd160, 9'd64);
		issue_pixel(9'd511, 9'd511);

		// Random views over the interesting region, one noise view with raw
		// words, and start gaps that rotate through none, heavy and light.
		for (phase = 0; phase < 10; phase++) begin
			wait_idle();
			idle_pct = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 88 : 16;
			if (phase == 4) begin
				set_view(rand_word(), rand_word(), rand_word() >> 2,
					WORD_W'($urandom_range(0, 8191)));
			end else begin
				// keep most limits small: each step waits on the bit-serial multipliers
				lim = ($urandom_range(9) == 0) ? WORD_W'($urandom_range(64, 200)) :
					WORD_W'($urandom_range(0, 48));
				set_view(FIX_NEG2P5 + (rand_word() >> 2), FIX_NEG2 + (rand_word() >> 2),
					rand_word() >> $urandom_range(11, 24), lim);
			end
			for (n = 0; n < 12; n++) begin
				issue_pixel(COORD_W'($urandom_range(0, 511)), COORD_W'($urandom_range(0, 511)));
			end
		end

		// Hold until every result is in, then let the clock run on before the verdict.
		wait_idle();
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Far beyond the slowest correct run, even with every pixel at the full limit.
	initial begin
		#1_000_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
design/mpi_pkg.sv
design/mpi_serial_mul.sv
design/mpi_point_map.sv
design/mandelbrot_pixel_iterator_core.sv
tb/mandelbrot_pixel_scoreboard.sv
tb/mandelbrot_pixel_iterator_core_tb.sv
